>>> design/rfr_pkg.sv
// Shared types, constants and the CRC byte update for the RTU frame receiver.
package rfr_pkg;

   localparam logic [15:0] CrcInit   = 16'hFFFF;
   localparam logic [15:0] CrcPoly   = 16'hA001;  // 0x8005 reflected
   localparam logic [8:0]  FixedLen  = 9'd8;
   localparam logic [8:0]  MultiBase = 9'd9;
   localparam logic [7:0]  FuncMulti = 8'd16;
   localparam logic [8:0]  PosFunc   = 9'd1;
   localparam logic [8:0]  PosLen    = 9'd6;
   localparam logic [8:0]  PosCrc    = 9'd2;

   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_FINAL    = 2'd1,
      KIND_PARTIAL  = 2'd2,
      KIND_OVERSIZE = 2'd3
   } kind_type;

   typedef enum logic {
      EVT_BYTE    = 1'b0,
      EVT_TIMEOUT = 1'b1
   } event_type;

   typedef struct packed {
      event_type  evt;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] frame_byte;
      logic [8:0] position;
      logic       last;
      logic       crc_ok;
      logic [8:0] dropped_count;
   } result_type;

   // handshake between the item queue, the frame engine and the result queue
   typedef struct packed {
      logic in_valid;
      logic out_full;
   } back_ctl_type;

   typedef struct packed {
      logic in_take;
      logic out_push;
   } back_sts_type;

   // CRC-16/MODBUS update by one byte, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> design/rfr_queue.sv
// Small register queue with push/full and pop/empty sides.
module rfr_queue #(
   parameter int WIDTH      = 10,
   parameter int DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int Depth = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      entry_ff [Depth];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == (DEPTH_LOG2 + 1)'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/rfr_back.sv
// Frame engine: position tracking, length decode, CRC check and result build.
module rfr_back #(
   parameter int MAX_FRAME = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rfr_pkg::back_ctl_type ctl,
   input  rfr_pkg::item_type    item,
   output rfr_pkg::back_sts_type sts,
   output rfr_pkg::result_type  result
);
   import rfr_pkg::*;

   localparam logic [8:0] MaxFrameW = 9'(MAX_FRAME);

   logic [8:0]  byte_count_ff, byte_count_in;
   logic [7:0]  func_code_ff, func_code_in;
   logic [8:0]  exp_len_ff, exp_len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] held_ff, held_in;
   logic        fire;
   logic [15:0] crc_next;
   logic [15:0] held_next;
   logic [7:0]  func_next;
   logic [8:0]  exp_next;
   logic [8:0]  cnt_next;
   logic        frame_done;

   assign fire = ctl.in_valid && !ctl.out_full;

   always_comb begin
      crc_next  = (byte_count_ff >= PosCrc) ? crc_feed(crc_ff, held_ff[15:8]) : crc_ff;
      held_next = {held_ff[7:0], item.rx_byte};
      func_next = func_code_ff;
      exp_next  = exp_len_ff;
      if (byte_count_ff == PosFunc) begin
         func_next = item.rx_byte;
         if (item.rx_byte != FuncMulti) begin
            exp_next = FixedLen;
         end
      end else if (byte_count_ff == PosLen && func_code_ff == FuncMulti) begin
         exp_next = MultiBase + {1'b0, item.rx_byte};
      end
      cnt_next   = byte_count_ff + 9'd1;
      frame_done = (exp_next != '0) && (cnt_next >= exp_next);
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      func_code_in  = func_code_ff;
      exp_len_in    = exp_len_ff;
      crc_in        = crc_ff;
      held_in       = held_ff;
      result        = '{kind: KIND_BYTE, frame_byte: item.rx_byte,
                        position: byte_count_ff, last: 1'b0, crc_ok: 1'b0,
                        dropped_count: '0};
      sts.in_take   = fire;
      sts.out_push  = 1'b0;
      if (item.evt == EVT_TIMEOUT) begin
         result = '{kind: KIND_PARTIAL, frame_byte: '0, position: '0, last: 1'b0,
                    crc_ok: 1'b0, dropped_count: byte_count_ff};
         if (fire && byte_count_ff != '0) begin
            sts.out_push  = 1'b1;
            byte_count_in = '0;
            func_code_in  = '0;
            exp_len_in    = '0;
            crc_in        = CrcInit;
            held_in       = '0;
         end
      end else begin
         sts.out_push = fire;
         if (frame_done) begin
            if (exp_next > MaxFrameW) begin
               result = '{kind: KIND_OVERSIZE, frame_byte: '0, position: '0,
                          last: 1'b0, crc_ok: 1'b0, dropped_count: exp_next};
            end else begin
               result.kind   = KIND_FINAL;
               result.last   = 1'b1;
               result.crc_ok = (held_next[15:8] == crc_next[7:0]) &&
                               (item.rx_byte == crc_next[15:8]);
            end
         end
         if (fire) begin
            if (frame_done) begin
               byte_count_in = '0;
               func_code_in  = '0;
               exp_len_in    = '0;
               crc_in        = CrcInit;
               held_in       = '0;
            end else begin
               byte_count_in = cnt_next;
               func_code_in  = func_next;
               exp_len_in    = exp_next;
               crc_in        = crc_next;
               held_in       = held_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         func_code_ff  <= '0;
         exp_len_ff    <= '0;
         crc_ff        <= CrcInit;
         held_ff       <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         func_code_ff  <= func_code_in;
         exp_len_ff    <= exp_len_in;
         crc_ff        <= crc_in;
         held_ff       <= held_in;
      end
   end

endmodule

>>> design/rtu_frame_receiver_crc16_top.sv
// Top level of the RTU frame receiver: item queue, frame engine, result queue.
// Path: an accepted beat is written to the item queue; the engine takes it once the
//   result queue has room and pushes its result there; the head drives the rsp_ ports.
// Throughput: one beat per cycle when the result queue has room (single-byte CRC step).
// Reset: synchronous, active high; empties both queues and returns the frame state
//   (count, function code, length, CRC 0xFFFF, held bytes) to its idle values.
module rtu_frame_receiver_crc16_top #(
   parameter int MAX_FRAME = 256
) (
   input  logic              clock,
   input  logic              reset,
   // input channel
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_mode,
   input  logic [7:0]        req_rx_byte,
   // result channel
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rfr_pkg::kind_type rsp_kind,
   output logic [7:0]        rsp_frame_byte,
   output logic [8:0]        rsp_position,
   output logic              rsp_last,
   output logic              rsp_crc_ok,
   output logic [8:0]        rsp_dropped_count
);
   import rfr_pkg::*;

   item_type     req_item;
   item_type     q_item;
   logic         item_empty;
   logic         res_full;
   back_ctl_type back_ctl;
   back_sts_type back_sts;
   result_type   back_result;
   result_type   rsp_result;

   // Front: classify the beat as a byte or a line-silence event.
   assign req_item.evt     = req_mode ? EVT_TIMEOUT : EVT_BYTE;
   assign req_item.rx_byte = req_rx_byte;

   // Short queue between front and frame engine; either side may stall.
   rfr_queue #(
      .WIDTH      ($bits(item_type)),
      .DEPTH_LOG2 (1)
   ) u_item_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (req_item),
      .full      (req_full),
      .pop       (back_sts.in_take),
      .pop_data  (q_item),
      .empty     (item_empty)
   );

   assign back_ctl.in_valid = !item_empty;
   assign back_ctl.out_full = res_full;

   // Back: frame state and CRC; one item per cycle when the result queue has room.
   rfr_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .ctl    (back_ctl),
      .item   (q_item),
      .sts    (back_sts),
      .result (back_result)
   );

   // Result queue: each result waits here until popped; the engine stalls while it is full.
   rfr_queue #(
      .WIDTH      ($bits(result_type)),
      .DEPTH_LOG2 (1)
   ) u_res_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_sts.out_push),
      .push_data (back_result),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_result),
      .empty     (rsp_empty)
   );

   assign rsp_kind          = rsp_result.kind;
   assign rsp_frame_byte    = rsp_result.frame_byte;
   assign rsp_position      = rsp_result.position;
   assign rsp_last          = rsp_result.last;
   assign rsp_crc_ok        = rsp_result.crc_ok;
   assign rsp_dropped_count = rsp_result.dropped_count;

   // last flag marks exactly the final-byte results
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last == (rsp_kind == KIND_FINAL)))
      else $error("last flag disagrees with result kind");

   // drop counts appear only on discard results, and then are nonzero
   a_drop_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_dropped_count != '0) ==
                      (rsp_kind == KIND_PARTIAL || rsp_kind == KIND_OVERSIZE)))
      else $error("dropped count on wrong result kind");

   // a byte's position never runs past the largest possible frame
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_position <= 9'd263))
      else $error("position out of range");

   // reset leaves no stale result behind
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the RTU frame receiver with CRC-16 check.
module tb;
   import rfr_pkg::*;

   localparam int MaxFrame = 256;

   // Function codes used to build traffic; 16 comes from the package.
   localparam logic [7:0] FnReadHolding = 8'd3;
   localparam logic [7:0] FnReadInput   = 8'd4;
   localparam logic [7:0] FnWriteSingle = 8'd6;

   // Reflected form of polynomial 0x8005.
   localparam logic [15:0] PolyRev = 16'hA001;

   typedef logic [7:0] octet_q_type[$];

   // Clock, reset and block inputs, all known from time zero.
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_push    = 1'b0;
   logic       req_mode    = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_pop     = 1'b0;

   logic       req_full;
   logic       rsp_empty;
   kind_type   rsp_kind;
   logic [7:0] rsp_frame_byte;
   logic [8:0] rsp_position;
   logic       rsp_last;
   logic       rsp_crc_ok;
   logic [8:0] rsp_dropped_count;

   // Results the tracker has worked out but the block has not yet delivered.
   result_type rsp_due[$];

   int err_count  = 0;
   int beats_sent = 0;
   // Set for the tail of the run: no idling on either side.
   bit calm       = 1'b0;

   // Receiver state as the tracker sees it.
   logic [8:0]  rx_count;
   logic [7:0]  fc;
   logic [8:0]  frame_len;   // zero while the length is still unknown
   logic [15:0] crc_run;     // CRC over all bytes except the newest two
   logic [15:0] last_two;    // newest byte in the low half

   rtu_frame_receiver_crc16_top #(
      .MAX_FRAME(MaxFrame)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_rx_byte      (req_rx_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_dropped_count(rsp_dropped_count)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // CRC and frame tracking
   // ------------------------------------------------------------------

   // Bit-serial CRC-16/MODBUS: each data bit is folded into the LSB in turn.
   function automatic logic [15:0] crc16_shift_in(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
         if (r[0] ^ d[k]) begin
            r = (r >> 1) ^ PolyRev;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   function automatic void track_clear();
      rx_count  = '0;
      fc        = '0;
      frame_len = '0;
      crc_run   = CrcInit;
      last_two  = '0;
   endfunction

   // Works out the result (if any) of one accepted beat and queues it.
   function automatic void track_event(input event_type evt, input logic [7:0] b);
      result_type r;
      logic [8:0] pos;
      r = '0;
      if (evt == EVT_TIMEOUT) begin
         // silence on an empty frame produces nothing
         if (rx_count == 0) return;
         r.kind          = KIND_PARTIAL;
         r.dropped_count = rx_count;
         track_clear();
         rsp_due.insert(rsp_due.size(), r);
         return;
      end
      pos = rx_count;
      // the CRC runs two bytes behind so the trailer never enters it
      if (pos >= 2) crc_run = crc16_shift_in(crc_run, last_two[15:8]);
      last_two = {last_two[7:0], b};
      if (pos == 1) begin
         fc = b;
         if (b != FuncMulti) frame_len = FixedLen;
      end else if (pos == 6 && fc == FuncMulti) begin
         frame_len = MultiBase + {1'b0, b};
      end
      rx_count     = pos + 9'd1;
      r.kind       = KIND_BYTE;
      r.frame_byte = b;
      r.position   = pos;
      if (frame_len != 0 && rx_count >= frame_len) begin
         if (frame_len > MaxFrame) begin
            r               = '0;
            r.kind          = KIND_OVERSIZE;
            r.dropped_count = frame_len;
         end else begin
            r.kind   = KIND_FINAL;
            r.last   = 1'b1;
            r.crc_ok = (last_two[15:8] == crc_run[7:0]) && (b == crc_run[15:8]);
         end
         track_clear();
      end
      rsp_due.insert(rsp_due.size(), r);
   endfunction

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Presents one beat and holds it until it is taken. An optional idle
   // burst goes in front, so push drops at the edge the last beat went in.
   task automatic send_beat(input event_type evt, input logic [7:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_mode    <= evt;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      track_event(evt, b);
      beats_sent++;
   endtask

   // Appends the CRC (optionally with one bit flipped) and sends the frame.
   // A cut position inside the frame sends only that many bytes, then silence.
   task automatic send_body(input octet_q_type body, input bit corrupt, input int cut_at);
      octet_q_type fr;
      logic [15:0] c;
      bit          cut;
      fr = body;
      c  = CrcInit;
      foreach (body[i]) c = crc16_shift_in(c, body[i]);
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
      fr.insert(fr.size(), c[7:0]);
      fr.insert(fr.size(), c[15:8]);
      cut = (cut_at > 0) && (cut_at < fr.size());
      if (cut) fr = fr[0:cut_at-1];
      foreach (fr[i]) send_beat(EVT_BYTE, fr[i]);
      if (cut) send_beat(EVT_TIMEOUT, 8'($urandom));
   endtask

   // Frame without its CRC: random address and data, count byte for code 16.
   function automatic octet_q_type make_body(input logic [7:0] code, input logic [7:0] cnt);
      octet_q_type q;
      int          len;
      len = (code == FuncMulti) ? 9 + int'(cnt) : 8;
      q.insert(q.size(), 8'($urandom));
      q.insert(q.size(), code);
      for (int i = 2; i < len - 2; i++) begin
         q.insert(q.size(), (i == 6 && code == FuncMulti) ? cnt : 8'($urandom));
      end
      return q;
   endfunction

   // ------------------------------------------------------------------
   // Result side: random pop stalls, every taken beat checked in order
   // ------------------------------------------------------------------

   task automatic cmp_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         err_count++;
      end
   endtask

   task automatic check_beat();
      result_type want;
      if (rsp_due.size() == 0) begin
         $display("%0t: result with none due, expected nothing, got kind %0d byte %0d pos %0d",
                  $time, rsp_kind, rsp_frame_byte, rsp_position);
         err_count++;
      end else begin
         want = rsp_due.pop_front();
         cmp_field("kind", want.kind, rsp_kind);
         cmp_field("frame_byte", want.frame_byte, rsp_frame_byte);
         cmp_field("position", want.position, rsp_position);
         cmp_field("last", want.last, rsp_last);
         cmp_field("crc_ok", want.crc_ok, rsp_crc_ok);
         cmp_field("dropped_count", want.dropped_count, rsp_dropped_count);
      end
   endtask

   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         // values read here are the ones from just before this edge
         if (rsp_pop && !rsp_empty) check_beat();
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Silence on an idle line, a fixed-length frame with a good CRC, a code 16
   // frame of minimum length with a bad CRC, and a partial frame cut by silence.
   task automatic test_directed();
      octet_q_type body;
      send_beat(EVT_TIMEOUT, 8'hFF);
      send_beat(EVT_TIMEOUT, 8'h00);
      body = '{8'hFF, FnReadHolding, 8'h00, 8'h00, 8'hFF, 8'hFF};
      send_body(body, 1'b0, 0);
      body = '{8'h00, FuncMulti, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
      send_body(body, 1'b1, 0);
      body = '{8'h01, FnWriteSingle, 8'hAA, 8'h55, 8'h00, 8'h01};
      send_body(body, 1'b0, 3);
      send_beat(EVT_TIMEOUT, 8'h5A);
   endtask

   // Shortest frame that no longer fits: one byte past the limit.
   task automatic test_frame_limits();
      send_body(make_body(FuncMulti, 8'(MaxFrame - 8)), 1'b0, 0);
   endtask

   // Mostly well-formed frames with random content; some carry a bad CRC,
   // some are cut off by silence, and some stretches are plain line noise.
   task automatic test_random_traffic();
      octet_q_type body;
      logic [7:0]  code;
      logic [7:0]  cnt;
      int          pick;
      while (beats_sent < 400) begin
         if (beats_sent > 340) calm = 1'b1;
         case ($urandom_range(0, 4))
            0:       code = FnReadHolding;
            1:       code = FnReadInput;
            2:       code = FnWriteSingle;
            3:       code = FuncMulti;
            default: code = 8'($urandom);
         endcase
         // code 16 frames stay short, with the odd large one
         cnt  = ($urandom_range(0, 39) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
         body = make_body(code, cnt);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_body(body, 1'b0, 0);
         end else if (pick == 7) begin
            send_body(body, 1'b1, 0);
         end else if (pick == 8) begin
            send_body(body, 1'b0, $urandom_range(1, body.size() + 1));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_beat(event_type'($urandom_range(0, 1)), 8'($urandom));
            end
            // usually resync the framing after noise
            if ($urandom_range(0, 3) != 0) send_beat(EVT_TIMEOUT, 8'($urandom));
         end
      end
   endtask

   initial begin
      track_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_frame_limits();
      test_random_traffic();
      req_push <= 1'b0;
      calm = 1'b1;
      while (rsp_due.size() != 0) @(posedge clock);
      // keep clocking to catch any result that should not be there
      repeat (8) @(posedge clock);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
